[design/lstp_pkg.sv]
// Shared types, constants and the CRC byte update for the scan telegram parser.
package lstp_pkg;

    typedef enum logic [2:0] {
        KIND_POINT      = 3'd0,
        KIND_OK         = 3'd1,
        KIND_CRC_ERR    = 3'd2,
        KIND_FORMAT_ERR = 3'd3,
        KIND_TIMEOUT    = 3'd4
    } kind_t;

    typedef enum logic {
        PH_HUNT = 1'b0,
        PH_BODY = 1'b1
    } phase_t;

    typedef enum logic [1:0] {
        CFG_DEVICE_FAMILY = 2'd0,
        CFG_BUS_SLAVE     = 2'd1
    } cfg_index_t;

    typedef struct packed {
        kind_t       kind;
        logic [9:0]  point_index;
        logic [16:0] distance_mm;
        logic        reflector;
    } result_t;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] MARKER_A     = 16'hBBBB;
    localparam logic [15:0] MARKER_B     = 16'h1111;
    localparam logic [7:0]  SYNC_BYTE    = 8'hFF;
    localparam logic [7:0]  MASTER_BYTE  = 8'h07;
    localparam logic [7:0]  SLAVE_BYTE   = 8'h08;
    localparam logic [15:0] MIN_WORDS    = 16'd12;
    localparam logic [15:0] MAX_WORDS    = 16'd2046;
    localparam logic [3:0]  HDR_LEN      = 4'd10;
    localparam logic [3:0]  HDR_ZEROS    = 4'd5;
    localparam logic [3:0]  HDR_CRC_FROM = 4'd4;
    localparam logic [3:0]  HDR_CNT_HI   = 4'd6;
    localparam logic [3:0]  HDR_CNT_LO   = 4'd7;
    localparam logic [3:0]  HDR_SYNC     = 4'd8;
    localparam logic [11:0] POS_MARKER_A = 12'd21;
    localparam logic [11:0] POS_MARKER_B = 12'd23;
    localparam logic [11:0] POS_POINTS   = 12'd25;
    localparam logic [15:0] WORDS_EXTRA  = 16'd11;

    // MSB-first CRC-16 update over one byte.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

[design/laser_scan_telegram_parser_unit.sv]
// Byte-stream parser for framed range-scanner telegrams with CRC and point output.
//
// Feed received serial bytes on the s_ channel; one byte is taken per clock
// cycle and each byte yields at most one result on the m_ channel: a scan point
// (m_tuser kind 0) or a frame status (ok, CRC error, format error) after the
// trailer (or, for a format error, after a header with a bad word count), or
// a sync timeout after HUNT_LIMIT bytes without a header. Points are sent as
// soon as their word arrives, so drop the points of any frame whose status is
// not ok. All parsing of a byte, including the byte-wide CRC update, happens
// in the cycle it is accepted; results then wait in a two-entry output buffer,
// and s_tready drops only while both entries are full. Configuration writes on
// the cfg_ channel are always accepted and take effect at the next header.
module laser_scan_telegram_parser_unit #(
    parameter int HUNT_LIMIT      = 4096,
    parameter int POINTS_FAMILY_A = 541,
    parameter int POINTS_FAMILY_B = 381
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [9:0] point_index, [26:10] distance_mm, [27] reflector
    output logic [2:0]  m_tuser,   // [2:0] kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data
);
    import lstp_pkg::*;

    localparam int HUNT_W = $clog2(HUNT_LIMIT + 1);
    localparam logic [HUNT_W-1:0] HUNT_MAX = HUNT_W'(HUNT_LIMIT);
    localparam logic [15:0] WORDS_A = 16'(POINTS_FAMILY_A) + WORDS_EXTRA;
    localparam logic [15:0] WORDS_B = 16'(POINTS_FAMILY_B) + WORDS_EXTRA;

    logic              device_family_reg;
    logic              bus_slave_reg;
    phase_t            phase_reg,       phase_next;
    logic [3:0]        hdr_pos_reg,     hdr_pos_next;
    logic [11:0]       byte_cnt_reg,    byte_cnt_next;
    logic [15:0]       word_count_reg,  word_count_next;
    logic [15:0]       crc_reg,         crc_next;
    logic [7:0]        low_byte_reg,    low_byte_next;
    logic              frame_ok_reg,    frame_ok_next;
    logic [9:0]        point_idx_reg,   point_idx_next;
    logic [HUNT_W-1:0] hunt_cnt_reg,    hunt_cnt_next;

    result_t           out_reg, skid_reg, res;
    logic              out_valid_reg, skid_valid_reg;
    logic              has_res, accept, push, pop;

    logic              hdr_match;
    logic [3:0]        hdr_pos_inc;
    logic [15:0]       wc_full;
    logic [HUNT_W-1:0] hunt_inc;
    logic [11:0]       last_crc, end_pos;
    logic [15:0]       word;
    logic [12:0]       range_raw;

    assign s_tready  = ~skid_valid_reg;
    assign accept    = s_tvalid & s_tready;
    assign push      = accept & has_res;
    assign pop       = out_valid_reg & m_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.reflector, out_reg.distance_mm, out_reg.point_index};
    assign m_tuser  = out_reg.kind;

    assign hdr_pos_inc = hdr_pos_reg + 4'd1;
    assign hunt_inc    = hunt_cnt_reg + HUNT_W'(1);
    assign wc_full     = {word_count_reg[15:8], s_tdata};
    assign last_crc    = {word_count_reg[10:0], 1'b1};
    assign end_pos     = last_crc + 12'd2;
    assign word        = {s_tdata, low_byte_reg};
    assign range_raw   = word[12:0];

    always_comb begin
        if (hdr_pos_reg <= HDR_ZEROS) begin
            hdr_match = (s_tdata == 8'h00);
        end else if (hdr_pos_reg == HDR_CNT_HI || hdr_pos_reg == HDR_CNT_LO) begin
            hdr_match = 1'b1;
        end else if (hdr_pos_reg == HDR_SYNC) begin
            hdr_match = (s_tdata == SYNC_BYTE);
        end else begin
            hdr_match = (s_tdata == (bus_slave_reg ? SLAVE_BYTE : MASTER_BYTE));
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        hdr_pos_next    = hdr_pos_reg;
        byte_cnt_next   = byte_cnt_reg;
        word_count_next = word_count_reg;
        crc_next        = crc_reg;
        low_byte_next   = low_byte_reg;
        frame_ok_next   = frame_ok_reg;
        point_idx_next  = point_idx_reg;
        hunt_cnt_next   = hunt_cnt_reg;
        has_res         = 1'b0;
        res             = '{kind: KIND_POINT, point_index: '0, distance_mm: '0, reflector: 1'b0};

        case (phase_reg)
            PH_HUNT: begin
                // The header CRC is built as the header bytes arrive; a restart
                // reloads it at the first CRC-covered byte.
                if (hdr_pos_reg == HDR_CRC_FROM) begin
                    crc_next = crc_feed(CRC_INIT, s_tdata);
                end else begin
                    crc_next = crc_feed(crc_reg, s_tdata);
                end
                if (hdr_pos_reg == HDR_CNT_HI) begin
                    word_count_next = {s_tdata, 8'h00};
                end else if (hdr_pos_reg == HDR_CNT_LO) begin
                    word_count_next = wc_full;
                end
                hdr_pos_next  = hdr_match ? hdr_pos_inc : 4'd0;
                hunt_cnt_next = hunt_inc;
                if (hdr_match && hdr_pos_inc == HDR_LEN) begin
                    hdr_pos_next  = 4'd0;
                    hunt_cnt_next = '0;
                    if (word_count_reg < MIN_WORDS || word_count_reg > MAX_WORDS) begin
                        has_res  = 1'b1;
                        res.kind = KIND_FORMAT_ERR;
                    end else begin
                        frame_ok_next  = (word_count_reg ==
                                          (device_family_reg ? WORDS_B : WORDS_A));
                        point_idx_next = '0;
                        byte_cnt_next  = 12'(HDR_LEN);
                        phase_next     = PH_BODY;
                    end
                end else if (hunt_inc >= HUNT_MAX) begin
                    hunt_cnt_next = '0;
                    hdr_pos_next  = 4'd0;
                    has_res       = 1'b1;
                    res.kind      = KIND_TIMEOUT;
                end
            end
            PH_BODY: begin
                byte_cnt_next = byte_cnt_reg + 12'd1;
                if (byte_cnt_reg <= last_crc) begin
                    crc_next = crc_feed(crc_reg, s_tdata);
                end
                if (!byte_cnt_reg[0]) begin
                    low_byte_next = s_tdata;
                end else if (byte_cnt_reg == end_pos) begin
                    has_res = 1'b1;
                    if (word != crc_reg) begin
                        res.kind = KIND_CRC_ERR;
                    end else if (!frame_ok_reg) begin
                        res.kind = KIND_FORMAT_ERR;
                    end else begin
                        res.kind = KIND_OK;
                    end
                    phase_next    = PH_HUNT;
                    hdr_pos_next  = 4'd0;
                    hunt_cnt_next = '0;
                    byte_cnt_next = '0;
                end else if (byte_cnt_reg == POS_MARKER_A) begin
                    if (word != MARKER_A) begin
                        frame_ok_next = 1'b0;
                    end
                end else if (byte_cnt_reg == POS_MARKER_B) begin
                    if (word != MARKER_B) begin
                        frame_ok_next = 1'b0;
                    end
                end else if (byte_cnt_reg >= POS_POINTS && byte_cnt_reg <= last_crc
                             && frame_ok_reg) begin
                    has_res         = 1'b1;
                    res.kind        = KIND_POINT;
                    res.point_index = point_idx_reg;
                    // Range times ten as two shifted copies.
                    res.distance_mm = {1'b0, range_raw, 3'b000} + {3'b000, range_raw, 1'b0};
                    res.reflector   = word[13];
                    point_idx_next  = point_idx_reg + 10'd1;
                end
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT;
            hdr_pos_reg    <= '0;
            byte_cnt_reg   <= '0;
            word_count_reg <= '0;
            crc_reg        <= CRC_INIT;
            low_byte_reg   <= '0;
            frame_ok_reg   <= 1'b0;
            point_idx_reg  <= '0;
            hunt_cnt_reg   <= '0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            hdr_pos_reg    <= hdr_pos_next;
            byte_cnt_reg   <= byte_cnt_next;
            word_count_reg <= word_count_next;
            crc_reg        <= crc_next;
            low_byte_reg   <= low_byte_next;
            frame_ok_reg   <= frame_ok_next;
            point_idx_reg  <= point_idx_next;
            hunt_cnt_reg   <= hunt_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_family_reg <= 1'b0;
            bus_slave_reg     <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DEVICE_FAMILY: device_family_reg <= cfg_data;
                CFG_BUS_SLAVE:     bus_slave_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Two-entry output buffer: the skid entry catches a result while the
    // head entry is stalled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg) begin
            out_valid_reg <= push;
        end else if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= push;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || (pop && !skid_valid_reg)) begin
            if (push) begin
                out_reg <= res;
            end
        end else if (pop) begin
            out_reg <= skid_reg;
        end
        if (push && out_valid_reg && (skid_valid_reg || !pop)) begin
            skid_reg <= res;
        end
    end

endmodule
